// ===== src/rps_pkg.sv =====
// Package for the random permutation shuffle block.
// Holds command/status codes and the input and result word structs. No dependencies.
package rps_pkg;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_STEP  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_FINISHED = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] data_in;
        logic [30:0]        random_word;
        logic [7:0]         read_index;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] data_value;
        logic [7:0]         chosen_index;
        logic [1:0]         status;
    } out_word_t;

endpackage

// ===== src/rps_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on nothing; used by rps_back.
module rps_div #(
    parameter int W = 31
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         go,
    input  logic [W-1:0] dividend,
    input  logic [W:0]   divisor,
    output logic         done,
    output logic [W-1:0] quotient
);
    localparam int CW = $clog2(W + 1);

    logic [W:0]   rem_reg;
    logic [W-1:0] quo_reg;
    logic [W:0]   dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [W+1:0] trial;
    logic [W:0]   shifted;

    assign shifted  = {rem_reg[W-1:0], quo_reg[W-1]};
    assign trial    = {1'b0, shifted} - {1'b0, dvs_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[W+1])
            begin
                rem_reg <= trial[W:0];
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
        end
    end
endmodule

// ===== src/rps_front.sv =====
// Front end: accepts command words into a two-entry queue.
// Depends on rps_pkg.
module rps_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  rps_pkg::in_word_t in_word,
    output logic              busy,
    output logic              q_valid,
    output rps_pkg::in_word_t q_word,
    input  logic              q_pop
);
    rps_pkg::in_word_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push;

    assign busy    = (cnt_reg == 2'd2);
    assign push    = start && !busy;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_word  = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (q_pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= in_word;
    end
endmodule

// ===== src/rps_back.sv =====
// Back end: executes commands against the element store, divider for steps.
// Depends on rps_pkg and rps_div.
module rps_back #(
    parameter int MAX_ITEMS  = 256,
    parameter int RANDOM_MAX = 2147483647
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  rps_pkg::in_word_t  q_word,
    output logic               q_pop,
    output logic               res_strobe,
    output rps_pkg::out_word_t res_word
);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int IW = $clog2(MAX_ITEMS);
    localparam logic [30:0] RMAX = 31'(RANDOM_MAX);

    typedef enum logic [3:0] {
        S_IDLE, S_DIV1, S_W1, S_DIV2, S_W2, S_RD, S_SWAP1, S_SWAP2, S_RDOUT
    } state_t;

    state_t state_reg;
    logic [31:0] mem [MAX_ITEMS];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] pos_reg;
    rps_pkg::in_word_t cur_reg;
    logic [31:0] rdata_reg, ei_reg;
    logic [IW-1:0] j_reg;
    logic [30:0] r_sat;
    logic        div_go;
    logic [30:0] div_a;
    logic [31:0] div_b;
    logic        div_done;
    logic [30:0] div_q;
    logic [31:0] span;
    logic [31:0] jsum;
    logic [30:0] dvs_reg;
    logic        we;
    logic [IW-1:0] waddr;
    logic [31:0] wdata;
    logic [IW-1:0] rd_addr_reg;

    function automatic rps_pkg::out_word_t mk_res(logic [31:0] v, logic [7:0] idx,
                                                  logic [1:0] st);
        rps_pkg::out_word_t r;
        r.data_value   = v;
        r.chosen_index = idx;
        r.status       = st;
        return r;
    endfunction

    rps_div #(.W(31)) u_div (
        .clk(clk), .rst_n(rst_n), .go(div_go), .dividend(div_a),
        .divisor(div_b), .done(div_done), .quotient(div_q)
    );

    assign span  = 32'(count_reg) - 32'(pos_reg);
    assign r_sat = (cur_reg.random_word > RMAX) ? RMAX : cur_reg.random_word;
    assign jsum  = 32'(pos_reg) + {1'b0, div_q};
    assign q_pop = (state_reg == S_IDLE) && q_valid;

    always_comb
    begin
        div_go = 1'b0;
        div_a  = RMAX;
        div_b  = span;
        if (state_reg == S_DIV1)
            div_go = 1'b1;
        else if (state_reg == S_DIV2)
        begin
            div_go = 1'b1;
            div_a  = r_sat;
            div_b  = {1'b0, dvs_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[rd_addr_reg];
    end

    // Single write port: append on load, two writes for a swap.
    always_comb
    begin
        we    = 1'b0;
        waddr = IW'(count_reg);
        wdata = q_word.data_in;
        if (state_reg == S_IDLE && q_valid && q_word.cmd == rps_pkg::CMD_LOAD &&
            count_reg < CW'(MAX_ITEMS))
            we = 1'b1;
        else if (state_reg == S_SWAP1)
        begin
            we = 1'b1; waddr = j_reg; wdata = ei_reg;
        end
        else if (state_reg == S_SWAP2)
        begin
            we = 1'b1; waddr = IW'(pos_reg); wdata = rdata_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            pos_reg    <= '0;
            res_strobe <= 1'b0;
        end
        else
        begin
            res_strobe <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        cur_reg <= q_word;
                        unique case (q_word.cmd)
                            rps_pkg::CMD_LOAD:
                            begin
                                if (count_reg >= CW'(MAX_ITEMS))
                                    res_word <= mk_res('0, '0, rps_pkg::ST_FULL);
                                else
                                begin
                                    res_word  <= mk_res('0, '0, rps_pkg::ST_OK);
                                    count_reg <= count_reg + 1'b1;
                                end
                                res_strobe <= 1'b1;
                            end
                            rps_pkg::CMD_STEP:
                            begin
                                if (count_reg < CW'(2) || pos_reg + 1'b1 >= count_reg)
                                begin
                                    res_word   <= mk_res('0, '0, rps_pkg::ST_FINISHED);
                                    res_strobe <= 1'b1;
                                end
                                else
                                begin
                                    rd_addr_reg <= IW'(pos_reg);
                                    state_reg   <= S_DIV1;
                                end
                            end
                            rps_pkg::CMD_READ:
                            begin
                                if (32'(q_word.read_index) < 32'(count_reg))
                                begin
                                    rd_addr_reg <= IW'(q_word.read_index);
                                    state_reg   <= S_RD;
                                end
                                else
                                begin
                                    res_word   <= mk_res('0, '0, rps_pkg::ST_RANGE);
                                    res_strobe <= 1'b1;
                                end
                            end
                            rps_pkg::CMD_CLEAR:
                            begin
                                count_reg  <= '0;
                                pos_reg    <= '0;
                                res_word   <= mk_res('0, '0, rps_pkg::ST_OK);
                                res_strobe <= 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                S_DIV1: state_reg <= S_W1;
                S_W1:
                    if (div_done)
                    begin
                        // entry i has been on rdata_reg since the divider started
                        ei_reg    <= rdata_reg;
                        dvs_reg   <= div_q + 1'b1;
                        state_reg <= S_DIV2;
                    end
                S_DIV2: state_reg <= S_W2;
                S_W2:
                    if (div_done)
                    begin
                        if (jsum >= 32'(count_reg))
                            j_reg <= IW'(count_reg - 1'b1);
                        else
                            j_reg <= IW'(jsum);
                        rd_addr_reg <= (jsum >= 32'(count_reg)) ?
                            IW'(count_reg - 1'b1) : IW'(jsum);
                        state_reg <= S_RD;
                    end
                S_RD:
                    state_reg <= (cur_reg.cmd == rps_pkg::CMD_READ) ? S_RDOUT : S_SWAP1;
                S_RDOUT:
                begin
                    res_word   <= mk_res(rdata_reg, '0, rps_pkg::ST_OK);
                    res_strobe <= 1'b1;
                    state_reg  <= S_IDLE;
                end
                S_SWAP1: state_reg <= S_SWAP2;
                S_SWAP2:
                begin
                    pos_reg    <= pos_reg + 1'b1;
                    res_word   <= mk_res('0, 8'(j_reg), rps_pkg::ST_OK);
                    res_strobe <= 1'b1;
                    state_reg  <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== src/random_permutation_shuffle_top.sv =====
// Top level of the Fisher-Yates shuffle engine.
// Depends on rps_pkg, rps_front, rps_back, rps_div.
//
// Usage:
//   Command words enter on start/cmd_word; a word is taken at a clock edge
//   with start high and busy low. A two-word queue decouples the front from
//   the back end, so busy rises only when both slots hold waiting words.
//   Each command yields exactly one result word on result_word, marked by a
//   one-cycle done strobe; the receiver must take it, it cannot stall.
//   A swap step runs two dependent passes of the radix-2 divider, one
//   after the other, then reads the chosen entry and does the two-write
//   swap through the single write port of the store.
//   Throughput is one command at a time through the back end.
//   Reset clears count, step position and queue; the store contents are
//   undefined until loaded and need no clearing pass.
module random_permutation_shuffle_top #(
    parameter int MAX_ITEMS  = 256,
    parameter int RANDOM_MAX = 2147483647
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  rps_pkg::in_word_t  cmd_word,
    output logic               busy,
    output logic               done,
    output rps_pkg::out_word_t result_word
);
    logic              q_valid;
    logic              q_pop;
    rps_pkg::in_word_t q_word;

    // Front: command queue.
    rps_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .in_word(cmd_word),
        .busy(busy), .q_valid(q_valid), .q_word(q_word), .q_pop(q_pop)
    );

    // Back: store, divider and swap sequencer.
    rps_back #(.MAX_ITEMS(MAX_ITEMS), .RANDOM_MAX(RANDOM_MAX)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_word(q_word),
        .q_pop(q_pop), .res_strobe(done), .res_word(result_word)
    );
endmodule
